/* design/tcdt_pkg.sv */
// Package for the TCP connection demux table: op and status codes, word types.
// No dependencies.
package tcdt_pkg;
    localparam int EstEntries = 64;
    localparam int LsnEntries = 16;
    localparam int HandleBits = 16;

    typedef enum logic [2:0] {
        OP_LOOKUP     = 3'd0,
        OP_LOOKUP_EST = 3'd1,
        OP_INS_LSN    = 3'd2,
        OP_REM_LSN    = 3'd3,
        OP_INS_EST    = 3'd4,
        OP_REM_EST    = 3'd5
    } t_op;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DUP      = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic [1:0] HIT_NONE = 2'd0;
    localparam logic [1:0] HIT_EST  = 2'd1;
    localparam logic [1:0] HIT_LSN  = 2'd2;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] remote_addr;
        logic [31:0] local_addr;
        logic [15:0] remote_tcp_port;
        logic [15:0] local_tcp_port;
        logic [15:0] socket_handle;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  hit_table;
        logic [15:0] found_handle;
    } t_rsp;

    // Search result of one table, handed to the control module.
    typedef struct packed {
        logic hit;
        logic full;
    } t_srch;
endpackage

/* design/tcdt_if.sv */
// Valid/ready channel carrying one word of type T.
// No dependencies.
interface tcdt_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/tcdt_table.sv */
// One associative table: valid bit registers plus key and handle memories read one entry a cycle.
// A search scans every entry, then the update is applied in the closing S_DONE state.
// Depends on tcdt_pkg.
module tcdt_table #(
    parameter int ENTRIES = 16,
    parameter int KEY_BITS = 48,
    parameter int HANDLE_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [KEY_BITS-1:0]         i_key,
    input  logic                        i_ins,
    input  logic                        i_rem,
    input  logic [HANDLE_BITS-1:0]      i_handle,
    output logic                        o_done,
    output tcdt_pkg::t_srch             o_srch,
    output logic [HANDLE_BITS-1:0]      o_handle
);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                 r_state;
    logic [ENTRIES-1:0]     r_valid;
    logic [KEY_BITS-1:0]    r_key [ENTRIES];
    logic [HANDLE_BITS-1:0] r_hmem [ENTRIES];
    logic [KEY_BITS-1:0]    r_kq;
    logic [HANDLE_BITS-1:0] r_hq;
    logic [IW-1:0]          r_raddr;
    logic [IW-1:0]          r_cidx;
    logic [IW-1:0]          r_hit_idx;
    logic                   r_rlast;
    logic                   r_rd_vld;
    logic                   r_hit;
    logic [HANDLE_BITS-1:0] r_hit_h;
    logic [IW-1:0]          w_free_idx;
    logic                   w_free;
    logic                   w_cmp;
    logic                   w_wr;
    logic                   w_clr;

    always_comb begin
        w_free_idx = '0;
        w_free = 1'b0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free_idx = IW'(i);
                w_free = 1'b1;
            end
        end
    end

    assign w_cmp = r_rd_vld && r_valid[r_cidx] && (r_kq == i_key);
    assign w_wr  = (r_state == S_DONE) && i_ins && !r_hit && w_free;
    assign w_clr = (r_state == S_DONE) && i_rem && r_hit;

    assign o_done      = r_state == S_DONE;
    assign o_srch.hit  = r_hit;
    assign o_srch.full = !w_free;
    assign o_handle    = r_hit_h;

    // key and handle memories: one read port, one write port
    always_ff @(posedge i_clk) begin
        r_kq <= r_key[r_raddr];
        r_hq <= r_hmem[r_raddr];
        if (w_wr) begin
            r_key[w_free_idx]  <= i_key;
            r_hmem[w_free_idx] <= i_handle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_raddr   <= '0;
            r_cidx    <= '0;
            r_rlast   <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_hit     <= 1'b0;
            r_hit_idx <= '0;
            r_hit_h   <= '0;
        end else begin
            r_rd_vld <= (r_state == S_SCAN) && !r_rlast;
            r_cidx   <= r_raddr;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_raddr <= '0;
                        r_rlast <= 1'b0;
                        r_hit   <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (!r_rlast) begin
                        if (r_raddr == IW'(ENTRIES - 1)) r_rlast <= 1'b1;
                        else r_raddr <= r_raddr + 1'b1;
                    end
                    if (w_cmp && !r_hit) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_cidx;
                        r_hit_h   <= r_hq;
                    end
                    if (r_rd_vld && (r_cidx == IW'(ENTRIES - 1))) r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_wr) r_valid[w_free_idx] <= 1'b1;
                    if (w_clr) r_valid[r_hit_idx] <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* design/tcp_connection_demux_table_top.sv */
// Top level of the TCP connection demux table: request and response channels.
// Depends on tcdt_pkg, tcdt_if, tcdt_table.
//
//  channel   dir  word     fields
//  i_req     in   t_req    op, addresses, ports, socket_handle
//  o_rsp     out  t_rsp    status, hit_table, found_handle
//
// Both tables scan one entry a cycle from the accept edge. The response word is
// registered in S_RESP once both tables are done; the next request is taken
// only back in S_IDLE, after that word is loaded. The established table scan
// decides when both are done while LSN_ENTRIES <= EST_ENTRIES. A stalled response
// holds the finished word. Reset clears all valid bits at once; no sweep.
module tcp_connection_demux_table_top #(
    parameter int EST_ENTRIES = tcdt_pkg::EstEntries,
    parameter int LSN_ENTRIES = tcdt_pkg::LsnEntries,
    parameter int HANDLE_BITS = tcdt_pkg::HandleBits
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tcdt_if.sink   i_req,
    tcdt_if.source o_rsp
);
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_RESP = 3'b100
    } t_state;

    t_state                 r_state;
    logic                   w_acc;
    logic                   w_out_free;
    logic                   r_ovalid;
    tcdt_pkg::t_req         r_req;
    tcdt_pkg::t_srch        w_est, w_lsn, r_est, r_lsn;
    logic                   w_est_done, w_lsn_done, r_est_done, r_lsn_done;
    logic [HANDLE_BITS-1:0] w_hnd, w_est_h, w_lsn_h, r_est_h, r_lsn_h;
    logic [1:0]             n_status, n_hit;
    tcdt_pkg::t_rsp         r_rsp;
    logic                   w_ins_e, w_rem_e, w_ins_l, w_rem_l;

    assign i_req.ready = i_rst_n && (r_state == S_IDLE);
    assign w_acc = i_req.valid && i_req.ready;
    assign w_out_free = !r_ovalid || o_rsp.ready;
    assign w_hnd = HANDLE_BITS'(r_req.socket_handle);
    assign w_ins_e = r_req.op == tcdt_pkg::OP_INS_EST;
    assign w_rem_e = r_req.op == tcdt_pkg::OP_REM_EST;
    assign w_ins_l = r_req.op == tcdt_pkg::OP_INS_LSN;
    assign w_rem_l = r_req.op == tcdt_pkg::OP_REM_LSN;

    tcdt_table #(.ENTRIES(EST_ENTRIES), .KEY_BITS(96), .HANDLE_BITS(HANDLE_BITS)) u_est (
        .i_clk, .i_rst_n,
        .i_start(w_acc),
        .i_key({r_req.remote_addr, r_req.local_addr, r_req.remote_tcp_port,
                r_req.local_tcp_port}),
        .i_ins(w_ins_e), .i_rem(w_rem_e), .i_handle(w_hnd),
        .o_done(w_est_done), .o_srch(w_est), .o_handle(w_est_h));

    tcdt_table #(.ENTRIES(LSN_ENTRIES), .KEY_BITS(48), .HANDLE_BITS(HANDLE_BITS)) u_lsn (
        .i_clk, .i_rst_n,
        .i_start(w_acc),
        .i_key({r_req.local_addr, r_req.local_tcp_port}),
        .i_ins(w_ins_l), .i_rem(w_rem_l), .i_handle(w_hnd),
        .o_done(w_lsn_done), .o_srch(w_lsn), .o_handle(w_lsn_h));

    always_comb begin
        n_status = tcdt_pkg::ST_NOTFOUND;
        n_hit = tcdt_pkg::HIT_NONE;
        case (r_req.op)
            tcdt_pkg::OP_LOOKUP, tcdt_pkg::OP_LOOKUP_EST: begin
                if (r_est.hit) begin
                    n_status = tcdt_pkg::ST_OK; n_hit = tcdt_pkg::HIT_EST;
                end else if (r_req.op == tcdt_pkg::OP_LOOKUP && r_lsn.hit) begin
                    n_status = tcdt_pkg::ST_OK; n_hit = tcdt_pkg::HIT_LSN;
                end
            end
            tcdt_pkg::OP_INS_LSN:
                n_status = r_lsn.hit ? tcdt_pkg::ST_DUP
                         : (r_lsn.full ? tcdt_pkg::ST_FULL : tcdt_pkg::ST_OK);
            tcdt_pkg::OP_REM_LSN:
                n_status = r_lsn.hit ? tcdt_pkg::ST_OK : tcdt_pkg::ST_NOTFOUND;
            tcdt_pkg::OP_INS_EST:
                n_status = (r_est.hit || !r_est.full) ? tcdt_pkg::ST_OK : tcdt_pkg::ST_FULL;
            tcdt_pkg::OP_REM_EST:
                n_status = r_est.hit ? tcdt_pkg::ST_OK : tcdt_pkg::ST_NOTFOUND;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) r_req <= i_req.data;
        if (w_est_done) begin
            r_est   <= w_est;
            r_est_h <= w_est_h;
        end
        if (w_lsn_done) begin
            r_lsn   <= w_lsn;
            r_lsn_h <= w_lsn_h;
        end
        if (r_state == S_RESP && w_out_free) begin
            r_rsp.status <= n_status;
            r_rsp.hit_table <= n_hit;
            r_rsp.found_handle <= (n_hit == tcdt_pkg::HIT_EST) ? 16'(r_est_h)
                                : (n_hit == tcdt_pkg::HIT_LSN) ? 16'(r_lsn_h) : 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
            r_est_done <= 1'b0;
            r_lsn_done <= 1'b0;
        end else begin
            if (r_state == S_RESP && w_out_free) r_ovalid <= 1'b1;
            else if (o_rsp.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_est_done <= 1'b0;
                        r_lsn_done <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_est_done) r_est_done <= 1'b1;
                    if (w_lsn_done) r_lsn_done <= 1'b1;
                    if ((r_est_done || w_est_done) && (r_lsn_done || w_lsn_done))
                        r_state <= S_RESP;
                end
                S_RESP: begin
                    if (w_out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data = r_rsp;

    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_req.ready) else $error("accept while busy");
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |=> (o_rsp.valid && $stable(o_rsp.data)))
        else $error("response word dropped");
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("bad state");
endmodule

/* sim/tcp_connection_demux_table_top_tb.sv */
// Testbench for tcp_connection_demux_table_top: directed and random table operations,
// checked word by word against a behavioral model of both tables.
// Depends on tcdt_pkg, tcdt_if and the RTL of the block.
`timescale 1ns / 1ps

module tcp_connection_demux_table_top_tb;
    localparam int WatchdogLimit = 2000;

    logic i_clk;
    logic i_rst_n;

    tcdt_if #(.T(tcdt_pkg::t_req)) req_if ();
    tcdt_if #(.T(tcdt_pkg::t_rsp)) rsp_if ();

    tcp_connection_demux_table_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // table model
    logic        est_used [tcdt_pkg::EstEntries];
    logic [95:0] est_tuple[tcdt_pkg::EstEntries];
    logic [15:0] est_sock [tcdt_pkg::EstEntries];
    logic        lsn_used [tcdt_pkg::LsnEntries];
    logic [47:0] lsn_tuple[tcdt_pkg::LsnEntries];
    logic [15:0] lsn_sock [tcdt_pkg::LsnEntries];

    tcdt_pkg::t_rsp rsp_pending[$];
    int   mismatches;
    int   words_sent;
    int   words_checked;
    int   idle_cycles;
    int   burst_left;

    // pool of keys so that hits and duplicates are frequent
    logic [31:0] pool_raddr[8];
    logic [31:0] pool_laddr[4];
    logic [15:0] pool_rport[8];
    logic [15:0] pool_lport[4];

    function automatic int est_index(logic [95:0] tuple);
        for (int i = 0; i < tcdt_pkg::EstEntries; i++)
            if (est_used[i] && est_tuple[i] == tuple) return i;
        return -1;
    endfunction

    function automatic int lsn_index(logic [47:0] tuple);
        for (int i = 0; i < tcdt_pkg::LsnEntries; i++)
            if (lsn_used[i] && lsn_tuple[i] == tuple) return i;
        return -1;
    endfunction

    function automatic tcdt_pkg::t_rsp demux_predict(tcdt_pkg::t_req r);
        tcdt_pkg::t_rsp rsp;
        logic [95:0]    four;
        logic [47:0]    two;
        int             idx;
        rsp  = '{status: tcdt_pkg::ST_NOTFOUND, hit_table: tcdt_pkg::HIT_NONE,
                 found_handle: '0};
        four = {r.remote_addr, r.local_addr, r.remote_tcp_port, r.local_tcp_port};
        two  = {r.local_addr, r.local_tcp_port};
        case (r.op)
            tcdt_pkg::OP_LOOKUP, tcdt_pkg::OP_LOOKUP_EST: begin
                idx = est_index(four);
                if (idx >= 0) begin
                    rsp = '{status: tcdt_pkg::ST_OK, hit_table: tcdt_pkg::HIT_EST,
                            found_handle: est_sock[idx]};
                end else if (r.op == tcdt_pkg::OP_LOOKUP) begin
                    idx = lsn_index(two);
                    if (idx >= 0)
                        rsp = '{status: tcdt_pkg::ST_OK, hit_table: tcdt_pkg::HIT_LSN,
                                found_handle: lsn_sock[idx]};
                end
            end
            tcdt_pkg::OP_INS_LSN: begin
                if (lsn_index(two) >= 0) begin
                    rsp.status = tcdt_pkg::ST_DUP;
                end else begin
                    rsp.status = tcdt_pkg::ST_FULL;
                    for (int i = 0; i < tcdt_pkg::LsnEntries; i++) begin
                        if (!lsn_used[i]) begin
                            lsn_used[i]  = 1'b1;
                            lsn_tuple[i] = two;
                            lsn_sock[i]  = r.socket_handle;
                            rsp.status   = tcdt_pkg::ST_OK;
                            break;
                        end
                    end
                end
            end
            tcdt_pkg::OP_REM_LSN: begin
                idx = lsn_index(two);
                if (idx >= 0) begin
                    lsn_used[idx] = 1'b0;
                    rsp.status    = tcdt_pkg::ST_OK;
                end
            end
            tcdt_pkg::OP_INS_EST: begin
                if (est_index(four) >= 0) begin
                    rsp.status = tcdt_pkg::ST_OK;
                end else begin
                    rsp.status = tcdt_pkg::ST_FULL;
                    for (int i = 0; i < tcdt_pkg::EstEntries; i++) begin
                        if (!est_used[i]) begin
                            est_used[i]  = 1'b1;
                            est_tuple[i] = four;
                            est_sock[i]  = r.socket_handle;
                            rsp.status   = tcdt_pkg::ST_OK;
                            break;
                        end
                    end
                end
            end
            tcdt_pkg::OP_REM_EST: begin
                idx = est_index(four);
                if (idx >= 0) begin
                    est_used[idx] = 1'b0;
                    rsp.status    = tcdt_pkg::ST_OK;
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    // sender: bursts with random gaps
    task automatic send_word(tcdt_pkg::t_req r);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 10);
        end
        burst_left--;
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do @(posedge i_clk); while (!(req_if.valid && req_if.ready));
        rsp_pending.push_back(demux_predict(r));
        words_sent++;
        @(negedge i_clk);
        if (burst_left == 0) req_if.valid <= 1'b0;
    endtask

    function automatic tcdt_pkg::t_req make_req(logic [2:0] op, logic [31:0] ra,
                                                logic [31:0] la, logic [15:0] rp,
                                                logic [15:0] lp, logic [15:0] h);
        tcdt_pkg::t_req r;
        r = '{op: op, remote_addr: ra, local_addr: la, remote_tcp_port: rp,
              local_tcp_port: lp, socket_handle: h};
        return r;
    endfunction

    function automatic tcdt_pkg::t_req random_req(logic [2:0] op);
        tcdt_pkg::t_req r;
        r.op              = op;
        r.remote_addr     = pool_raddr[$urandom_range(0, 7)];
        r.local_addr      = pool_laddr[$urandom_range(0, 3)];
        r.remote_tcp_port = pool_rport[$urandom_range(0, 7)];
        r.local_tcp_port  = pool_lport[$urandom_range(0, 3)];
        r.socket_handle   = 16'($urandom);
        if ($urandom_range(0, 9) == 0) begin
            r.remote_addr     = $urandom;
            r.local_addr      = $urandom;
            r.remote_tcp_port = 16'($urandom);
            r.local_tcp_port  = 16'($urandom);
        end
        return r;
    endfunction

    task automatic test_directed();
        send_word(make_req(tcdt_pkg::OP_LOOKUP, '0, '0, '0, '0, '0));
        send_word(make_req(tcdt_pkg::OP_REM_LSN, '1, '1, '1, '1, '1));
        send_word(make_req(tcdt_pkg::OP_REM_EST, '1, '1, '1, '1, '1));
        send_word(make_req(tcdt_pkg::OP_INS_LSN, '0, '1, '0, '1, '1));
        send_word(make_req(tcdt_pkg::OP_INS_LSN, '0, '1, '0, '1, 16'h1234));
        send_word(make_req(tcdt_pkg::OP_LOOKUP, 32'h0a000001, '1, 16'd80, '1, '0));
        send_word(make_req(tcdt_pkg::OP_LOOKUP_EST, 32'h0a000001, '1, 16'd80, '1, '0));
        send_word(make_req(tcdt_pkg::OP_INS_EST, '1, '0, '1, '0, 16'hffff));
        send_word(make_req(tcdt_pkg::OP_INS_EST, '1, '0, '1, '0, 16'h0001));
        send_word(make_req(tcdt_pkg::OP_LOOKUP, '1, '0, '1, '0, '0));
        send_word(make_req(tcdt_pkg::OP_INS_EST, 32'h0a000001, '1, 16'd80, '1, 16'h5555));
        send_word(make_req(tcdt_pkg::OP_LOOKUP, 32'h0a000001, '1, 16'd80, '1, '0));
        send_word(make_req(tcdt_pkg::OP_REM_EST, 32'h0a000001, '1, 16'd80, '1, '0));
        send_word(make_req(tcdt_pkg::OP_LOOKUP_EST, 32'h0a000001, '1, 16'd80, '1, '0));
        send_word(make_req(tcdt_pkg::OP_REM_LSN, '0, '1, '0, '1, '0));
        send_word(make_req(tcdt_pkg::OP_LOOKUP, 32'h0a000001, '1, 16'd80, '1, '0));
        send_word(make_req(3'd6, '1, '1, '1, '1, '1));
        send_word(make_req(3'd7, '1, '1, '1, '1, '1));
        send_word(make_req(tcdt_pkg::OP_REM_EST, '1, '0, '1, '0, '0));
    endtask

    // fill both tables past capacity, then drain them
    task automatic test_full_tables();
        for (int i = 0; i < tcdt_pkg::LsnEntries + 2; i++)
            send_word(make_req(tcdt_pkg::OP_INS_LSN, '0, 32'hc0a80000 + i, '0,
                               16'(i), 16'(i)));
        for (int i = 0; i < tcdt_pkg::EstEntries + 2; i++)
            send_word(make_req(tcdt_pkg::OP_INS_EST, 32'h08080000 + i, 32'hc0a80001,
                               16'(1000 + i), 16'd443, 16'(16'ha000 + i)));
        for (int i = 0; i < tcdt_pkg::LsnEntries + 2; i++)
            send_word(make_req(tcdt_pkg::OP_LOOKUP, '0, 32'hc0a80000 + i, '0,
                               16'(i), '0));
        for (int i = tcdt_pkg::EstEntries + 1; i >= 0; i--)
            send_word(make_req(tcdt_pkg::OP_REM_EST, 32'h08080000 + i, 32'hc0a80001,
                               16'(1000 + i), 16'd443, '0));
        for (int i = 0; i < tcdt_pkg::LsnEntries + 2; i++)
            send_word(make_req(tcdt_pkg::OP_REM_LSN, '0, 32'hc0a80000 + i, '0,
                               16'(i), '0));
    endtask

    task automatic test_random(int count);
        logic [2:0] op;
        for (int i = 0; i < count; i++) begin
            op = $urandom_range(0, 19) == 0 ? 3'($urandom_range(6, 7))
                                            : 3'($urandom_range(0, 5));
            send_word(random_req(op));
        end
    endtask

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (!i_rst_n) rsp_if.ready <= 1'b0;
        else if (words_sent % 97 < 30) rsp_if.ready <= 1'b1;
        else rsp_if.ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (rsp_pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: unexpected response word %p", rsp_if.data);
            end else begin
                tcdt_pkg::t_rsp exp_rsp;
                exp_rsp = rsp_pending.pop_front();
                words_checked++;
                if (rsp_if.data !== exp_rsp) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: word %0d expected %p got %p",
                                 words_checked, exp_rsp, rsp_if.data);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("ERROR: watchdog expired");
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;
        mismatches   = 0;
        words_sent   = 0;
        words_checked = 0;
        idle_cycles  = 0;
        burst_left   = 0;
        for (int i = 0; i < tcdt_pkg::EstEntries; i++) est_used[i] = 1'b0;
        for (int i = 0; i < tcdt_pkg::LsnEntries; i++) lsn_used[i] = 1'b0;
        foreach (pool_raddr[i]) pool_raddr[i] = $urandom;
        foreach (pool_laddr[i]) pool_laddr[i] = $urandom;
        foreach (pool_rport[i]) pool_rport[i] = 16'($urandom);
        foreach (pool_lport[i]) pool_lport[i] = 16'($urandom);
        pool_laddr[0] = '0;
        pool_raddr[7] = '1;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_full_tables();
        test_random(450);
        if (burst_left != 0) req_if.valid <= 1'b0;

        while (rsp_pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Covered %0d request words, %0d responses checked, incl. full tables",
                 words_sent, words_checked);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

/* filelist.f */
design/tcdt_pkg.sv
design/tcdt_if.sv
design/tcdt_table.sv
design/tcp_connection_demux_table_top.sv
sim/tcp_connection_demux_table_top_tb.sv
